@@ hdl/bscrm_pkg.sv @@
// Shared types and constants for the bit string common run match unit.
`timescale 1ns / 1ps

package bscrm_pkg;

  localparam int STR_W     = 64;
  localparam int LEN_W     = 7;
  localparam int FRAC_W    = 17;
  localparam int FRAC_FBITS = 16;
  localparam int PROD_W    = LEN_W + FRAC_W;

  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  typedef struct packed {
    logic [STR_W-1:0]  key_bits;
    logic [LEN_W-1:0]  key_len;
    logic [STR_W-1:0]  lock_bits;
    logic [LEN_W-1:0]  lock_len;
    logic [FRAC_W-1:0] match_fraction;
  } in_item_t;

  typedef struct packed {
    logic             matched;
    logic [LEN_W-1:0] longest_run;
    logic [LEN_W-1:0] needed_run;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic finish;
  } ctl_t;

endpackage

@@ hdl/bit_string_common_run_match_unit.sv @@
// Top level: longest common run of two bit strings against a needed run length.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall  | in_item_t: key, lock, lengths, fraction
//   out_    | output    | out_valid/out_stall| out_item_t: matched, longest, needed
//
// Each item passes a capture step, a run over the key bits in ST_RUN (skipped when either
// string is empty) at one key bit per cycle through the lane counter row, and a hand-off step.
// The key bit loop over the shared lane row sets the rate; a new item is taken only in idle.
// Result is held in an output register; the hand-off cycle waits while it is
// still stalled. Synchronous active-low reset clears the sequencer and out_valid.
`timescale 1ns / 1ps

module bit_string_common_run_match_unit
  import bscrm_pkg::*;
#(
  parameter int MAX_BITS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int RUN_W = $clog2(MAX_BITS + 1);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_BITS);

  ctl_t                ctl;
  logic [RUN_W-1:0]    klen_lim, llen_lim;
  logic [FRAC_W-1:0]   frac_lim;
  logic [PROD_W-1:0]   prod;
  logic                nonempty;
  logic                out_free;
  logic [RUN_W-1:0]    best_run;

  logic [MAX_BITS-1:0] key_r;
  logic [MAX_BITS-1:0] lock_r;
  logic [RUN_W-1:0]    llen_r;
  logic [LEN_W-1:0]    needed_r;
  logic                nonempty_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  assign klen_lim = (in_data.key_len > LEN_CAP) ? RUN_W'(MAX_BITS)
                                                : in_data.key_len[RUN_W-1:0];
  assign llen_lim = (in_data.lock_len > LEN_CAP) ? RUN_W'(MAX_BITS)
                                                 : in_data.lock_len[RUN_W-1:0];
  assign frac_lim = (in_data.match_fraction > FRAC_ONE) ? FRAC_ONE
                                                        : in_data.match_fraction;
  assign prod     = PROD_W'(klen_lim) * PROD_W'(frac_lim);
  assign nonempty = (klen_lim != '0) && (llen_lim != '0);
  assign out_free = !out_valid_r || !out_stall;

  bscrm_ctrl #(
    .RUN_W (RUN_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .nonempty (nonempty),
    .key_len  (klen_lim),
    .out_free (out_free),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  bscrm_lanes #(
    .MAX_BITS (MAX_BITS),
    .RUN_W    (RUN_W)
  ) u_lanes (
    .clk       (clk),
    .ctl       (ctl),
    .key_bit   (key_r[0]),
    .lock_bits (lock_r),
    .lock_len  (llen_r),
    .best_run  (best_run)
  );

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      key_r      <= in_data.key_bits[MAX_BITS-1:0];
      lock_r     <= in_data.lock_bits[MAX_BITS-1:0];
      llen_r     <= llen_lim;
      needed_r   <= prod[FRAC_FBITS +: LEN_W];
      nonempty_r <= nonempty;
    end else if (ctl.step) begin
      key_r <= key_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_data_r.matched     <= nonempty_r && (LEN_W'(best_run) >= needed_r);
      out_data_r.longest_run <= LEN_W'(best_run);
      out_data_r.needed_run  <= needed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_match_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.matched ||
                     (out_data_r.longest_run >= out_data_r.needed_run)))
    else $error("matched set with longest run below needed run");

  a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.longest_run <= LEN_CAP))
    else $error("longest run beyond string capacity");

  a_best_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step |=> (({1'b0, best_run} == {1'b0, $past(best_run)}) ||
                  ({1'b0, best_run} == {1'b0, $past(best_run)} + 1'b1)))
    else $error("best run moved by more than one per key bit");

endmodule

@@ hdl/bscrm_lanes.sv @@
// Row of run counters, one per lock position, with the running best run.
`timescale 1ns / 1ps

module bscrm_lanes
  import bscrm_pkg::*;
#(
  parameter int MAX_BITS = 64,
  parameter int RUN_W    = 7
) (
  input  logic                clk,
  input  ctl_t                ctl,
  input  logic                key_bit,
  input  logic [MAX_BITS-1:0] lock_bits,
  input  logic [RUN_W-1:0]    lock_len,
  output logic [RUN_W-1:0]    best_run
);

  logic [RUN_W-1:0] row_r   [MAX_BITS];
  logic [RUN_W-1:0] row_nxt [MAX_BITS];
  logic [RUN_W-1:0] best_r;
  logic [MAX_BITS-1:0] lane_hit;
  logic [RUN_W:0]      best_inc;

  assign best_inc = {1'b0, best_r} + 1'b1;

  always_comb begin
    for (int j = 0; j < MAX_BITS; j++) begin
      if ((RUN_W'(j) < lock_len) && (key_bit == lock_bits[j])) begin
        row_nxt[j] = (j == 0) ? RUN_W'(1) : row_r[(j == 0) ? 0 : j - 1] + 1'b1;
      end else begin
        row_nxt[j] = '0;
      end
      lane_hit[j] = ({1'b0, row_nxt[j]} == best_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      best_r <= '0;
      for (int j = 0; j < MAX_BITS; j++) begin
        row_r[j] <= '0;
      end
    end else if (ctl.step) begin
      if (|lane_hit) begin
        best_r <= best_inc[RUN_W-1:0];
      end
      for (int j = 0; j < MAX_BITS; j++) begin
        row_r[j] <= row_nxt[j];
      end
    end
  end

  assign best_run = best_r;

endmodule

@@ hdl/bscrm_ctrl.sv @@
// Sequencer: capture, one key bit per cycle, result hand-off.
`timescale 1ns / 1ps

module bscrm_ctrl
  import bscrm_pkg::*;
#(
  parameter int RUN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             nonempty,
  input  logic [RUN_W-1:0] key_len,
  input  logic             out_free,
  output logic             in_stall,
  output ctl_t             ctl
);

  state_t           state_r, state_nxt;
  logic [RUN_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = nonempty ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (cnt_r == RUN_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    ctl.capture = (state_r == ST_IDLE) && in_valid;
    ctl.step    = (state_r == ST_RUN);
    ctl.finish  = (state_r == ST_DONE) && out_free;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.capture) begin
      cnt_nxt = key_len;
    end else if (ctl.step) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
